// ===== hw/rtl/led_strip_fill_and_serialize_defines.svh =====
`ifndef LED_STRIP_FILL_AND_SERIALIZE_DEFINES_SVH
`define LED_STRIP_FILL_AND_SERIALIZE_DEFINES_SVH

// same-cycle implication on clk, held off during reset
`define LSFS_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, held off during reset
`define LSFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/lsfs_pkg.sv =====
`default_nettype none

package lsfs_pkg;

	localparam int IDX_W   = 6;
	localparam int LEVEL_W = 8;
	localparam int CH_W    = 5;
	localparam int COL_W   = 3 * CH_W;
	localparam int FRAME_W = 16;
	localparam int CLK_W   = 9;
	localparam int CLKS_PER_LED = 8;

	localparam logic [FRAME_W-1:0] START_BIT = 16'h8000;

	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_LATCH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_RD,
		ST_LD,
		ST_LATCH
	} lsfs_state_t;

	typedef struct packed {
		logic capture;
		logic fill_wr;
		logic cnt_clr;
		logic rd;
		logic load_frame;
		logic load_latch;
	} lsfs_cmd_t;

	typedef struct packed {
		logic fill_done;
		logic emit_last;
		logic out_free;
	} lsfs_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lsfs_if.sv =====
`default_nettype none

interface lsfs_in_if;
	import lsfs_pkg::*;

	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   first_index;
	logic [IDX_W-1:0]   last_index;
	logic [LEVEL_W-1:0] red_level;
	logic [LEVEL_W-1:0] green_level;
	logic [LEVEL_W-1:0] blue_level;

	modport source(output valid, first_index, last_index, red_level, green_level,
		blue_level, input ready);
	modport sink(input valid, first_index, last_index, red_level, green_level,
		blue_level, output ready);
endinterface

interface lsfs_out_if;
	import lsfs_pkg::*;

	logic               valid;
	logic               ready;
	logic               item_kind;
	logic [FRAME_W-1:0] frame_word;
	logic [CLK_W-1:0]   latch_clocks;
	logic               last_of_run;

	modport source(output valid, item_kind, frame_word, latch_clocks, last_of_run,
		input ready);
	modport sink(input valid, item_kind, frame_word, latch_clocks, last_of_run,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lsfs_ctrl.sv =====
`default_nettype none

module lsfs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output lsfs_pkg::lsfs_cmd_t cmd,
	input  lsfs_pkg::lsfs_sts_t sts
);
	import lsfs_pkg::*;

	lsfs_state_t state_q;
	lsfs_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_FILL;
				end
			end
			ST_FILL: begin
				if (sts.fill_done) begin
					cmd.cnt_clr = 1'b1;
					state_d     = ST_RD;
				end else begin
					cmd.fill_wr = 1'b1;
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_LD;
			end
			ST_LD: begin
				if (sts.out_free) begin
					cmd.load_frame = 1'b1;
					state_d        = sts.emit_last ? ST_LATCH : ST_RD;
				end
			end
			ST_LATCH: begin
				if (sts.out_free) begin
					cmd.load_latch = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lsfs_dp.sv =====
`default_nettype none

module lsfs_dp #(
	parameter int NUM_LEDS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [lsfs_pkg::IDX_W-1:0]   first_index,
	input  logic [lsfs_pkg::IDX_W-1:0]   last_index,
	input  logic [lsfs_pkg::LEVEL_W-1:0] red_level,
	input  logic [lsfs_pkg::LEVEL_W-1:0] green_level,
	input  logic [lsfs_pkg::LEVEL_W-1:0] blue_level,
	input  lsfs_pkg::lsfs_cmd_t          cmd,
	output lsfs_pkg::lsfs_sts_t          sts,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         item_kind,
	output logic [lsfs_pkg::FRAME_W-1:0] frame_word,
	output logic [lsfs_pkg::CLK_W-1:0]   latch_clocks,
	output logic                         last_of_run
);
	import lsfs_pkg::*;

	localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(NUM_LEDS - 1);
	localparam logic [CLK_W-1:0] LATCH_CLKS  = CLK_W'(CLKS_PER_LED * NUM_LEDS);

	logic [COL_W-1:0]   mem_q [NUM_LEDS];
	logic [NUM_LEDS-1:0] vld_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   last_q;
	logic [COL_W-1:0]   word_q;
	logic [COL_W-1:0]   rd_data_s1;
	logic               rd_vld_s1;
	logic [AW-1:0]      addr;
	logic [COL_W-1:0]   pixel;

	logic               out_vld_q;
	logic               kind_q;
	logic [FRAME_W-1:0] frame_q;
	logic [CLK_W-1:0]   clks_q;
	logic               last_run_q;

	assign addr  = cnt_q[AW-1:0];
	assign pixel = rd_vld_s1 ? rd_data_s1 : '0;

	// clamp the range end to the strip
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			last_q <= (last_index > LAST_IDX) ? LAST_IDX : last_index;
			word_q <= {blue_level[CH_W-1:0], red_level[CH_W-1:0], green_level[CH_W-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			vld_q <= '0;
		end else begin
			if (cmd.capture) begin
				cnt_q <= first_index;
			end else if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.fill_wr || cmd.load_frame) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
			if (cmd.fill_wr) begin
				vld_q[addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_wr) begin
			mem_q[addr] <= word_q;
		end
		if (cmd.rd) begin
			rd_data_s1 <= mem_q[addr];
			rd_vld_s1  <= vld_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load_frame || cmd.load_latch) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_frame) begin
			kind_q     <= KIND_FRAME;
			frame_q    <= START_BIT | FRAME_W'(pixel);
			clks_q     <= '0;
			last_run_q <= 1'b0;
		end else if (cmd.load_latch) begin
			kind_q     <= KIND_LATCH;
			frame_q    <= '0;
			clks_q     <= LATCH_CLKS;
			last_run_q <= 1'b1;
		end
	end

	assign sts.fill_done = (cnt_q > last_q);
	assign sts.emit_last = (cnt_q == LAST_IDX);
	assign sts.out_free  = !out_vld_q || out_ready;

	assign out_valid    = out_vld_q;
	assign item_kind    = kind_q;
	assign frame_word   = frame_q;
	assign latch_clocks = clks_q;
	assign last_of_run  = last_run_q;

endmodule

`default_nettype wire

// ===== hw/rtl/led_strip_fill_and_serialize.sv =====
// Fills a range of an RGB555 pixel store with one colour, then emits the whole strip as
// one 16-bit frame per pixel (start bit, then blue, red, green, MSB first) followed by a
// latch beat giving 8*NUM_LEDS zero clocks. The store is black after reset through
// per-pixel valid flags, so no clearing pass is needed. A command is accepted, the range
// is written pixel by pixel and the fill is ended, then each pixel is read from the store
// and loaded into the output register, and the latch beat follows; the pace is set by the
// single store port and its registered read, and a stalling sink holds the output.
// The next command is taken as soon as the latch beat sits in the output register.
`default_nettype none

module led_strip_fill_and_serialize #(
	parameter int NUM_LEDS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	lsfs_in_if.sink           fill,
	lsfs_out_if.source        strip
);
	import lsfs_pkg::*;

	lsfs_cmd_t cmd;
	lsfs_sts_t sts;

	lsfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fill.valid),
		.in_ready (fill.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	lsfs_dp #(
		.NUM_LEDS (NUM_LEDS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.first_index  (fill.first_index),
		.last_index   (fill.last_index),
		.red_level    (fill.red_level),
		.green_level  (fill.green_level),
		.blue_level   (fill.blue_level),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (strip.valid),
		.out_ready    (strip.ready),
		.item_kind    (strip.item_kind),
		.frame_word   (strip.frame_word),
		.latch_clocks (strip.latch_clocks),
		.last_of_run  (strip.last_of_run)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/lsfs_checker.sv =====
`default_nettype none

`include "led_strip_fill_and_serialize_defines.svh"

module lsfs_checker #(
	parameter int NUM_LEDS = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         item_kind,
	input logic [lsfs_pkg::FRAME_W-1:0] frame_word,
	input logic [lsfs_pkg::CLK_W-1:0]   latch_clocks,
	input logic                         last_of_run
);
	import lsfs_pkg::*;

	localparam logic [CLK_W-1:0] LATCH_CLKS = CLK_W'(CLKS_PER_LED * NUM_LEDS);

	// pixel beats carry the start bit and nothing of the latch
	`LSFS_ASSERT(a_frame_fmt, out_valid && item_kind == KIND_FRAME, frame_word[FRAME_W-1] && latch_clocks == '0 && !last_of_run, "malformed pixel beat")

	`LSFS_ASSERT(a_latch_fmt, out_valid && item_kind == KIND_LATCH, frame_word == '0 && latch_clocks == LATCH_CLKS && last_of_run, "malformed latch beat")

	// one command at a time
	`LSFS_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "command taken while busy")

	`LSFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(frame_word) && $stable(item_kind) && $stable(latch_clocks), "stalled beat changed")

endmodule

bind led_strip_fill_and_serialize lsfs_checker #(
	.NUM_LEDS (NUM_LEDS)
) u_lsfs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (fill.valid),
	.in_ready     (fill.ready),
	.out_valid    (strip.valid),
	.out_ready    (strip.ready),
	.item_kind    (strip.item_kind),
	.frame_word   (strip.frame_word),
	.latch_clocks (strip.latch_clocks),
	.last_of_run  (strip.last_of_run)
);

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import lsfs_pkg::*;

	localparam int NUM_LEDS   = 16;
	localparam int CYCLE_CAP  = 200000;
	localparam int HOLD_AT    = 300;
	localparam int HOLD_LEN   = 250;
	localparam int RANDOM_CMDS = 155;
	localparam int N_DIRECTED = 15;

	typedef struct packed {
		logic [IDX_W-1:0]   first_index;
		logic [IDX_W-1:0]   last_index;
		logic [LEVEL_W-1:0] red_level;
		logic [LEVEL_W-1:0] green_level;
		logic [LEVEL_W-1:0] blue_level;
	} fill_cmd_t;

	typedef struct packed {
		fill_cmd_t          cmd;
		logic               typed;
		logic [FRAME_W-1:0] frame;
	} directed_row_t;

	typedef struct packed {
		logic               item_kind;
		logic [FRAME_W-1:0] frame_word;
		logic [CLK_W-1:0]   latch_clocks;
		logic               last_of_run;
	} strip_beat_t;

	// typed rows: every pixel frame of the refresh carries the given word
	localparam directed_row_t DIRECTED_ROWS[N_DIRECTED] = '{
		'{'{6'd63, 6'd0,  8'h00, 8'h00, 8'h00}, 1'b1, 16'h8000},
		'{'{6'd0,  6'd63, 8'hFF, 8'hFF, 8'hFF}, 1'b1, 16'hFFFF},
		'{'{6'd0,  6'd15, 8'h1F, 8'h00, 8'h00}, 1'b1, 16'h83E0},
		'{'{6'd0,  6'd15, 8'h00, 8'h1F, 8'h00}, 1'b1, 16'h801F},
		'{'{6'd0,  6'd15, 8'h00, 8'h00, 8'h1F}, 1'b1, 16'hFC00},
		'{'{6'd0,  6'd15, 8'hE0, 8'hE0, 8'hE0}, 1'b1, 16'h8000},
		'{'{6'd16, 6'd63, 8'h55, 8'h55, 8'h55}, 1'b1, 16'h8000},
		'{'{6'd5,  6'd4,  8'h11, 8'h12, 8'h13}, 1'b0, 16'h0000},
		'{'{6'd3,  6'd3,  8'h0A, 8'h15, 8'h1B}, 1'b0, 16'h0000},
		'{'{6'd15, 6'd15, 8'hF1, 8'h2E, 8'h07}, 1'b0, 16'h0000},
		'{'{6'd0,  6'd0,  8'h1E, 8'h01, 8'h10}, 1'b0, 16'h0000},
		'{'{6'd10, 6'd40, 8'h33, 8'hCC, 8'h5A}, 1'b0, 16'h0000},
		'{'{6'd63, 6'd63, 8'h7F, 8'h80, 8'hA5}, 1'b0, 16'h0000},
		'{'{6'd8,  6'd12, 8'hAA, 8'h55, 8'h0F}, 1'b0, 16'h0000},
		'{'{6'd2,  6'd13, 8'h9C, 8'h63, 8'hB8}, 1'b0, 16'h0000}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lsfs_in_if  fill_bus();
	lsfs_out_if strip_bus();

	led_strip_fill_and_serialize #(.NUM_LEDS(NUM_LEDS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.fill   (fill_bus.sink),
		.strip  (strip_bus.source)
	);

	logic [COL_W-1:0] pixel_colour [NUM_LEDS];
	strip_beat_t      pending_beats[$];
	int               failures = 0;
	int               beats_seen = 0;
	int               tx_idle = 6;
	int               rx_idle = 70;
	int               hold_left = 0;
	bit               hold_done = 1'b0;
	int               cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// paint the range, then queue the whole strip refresh
	task automatic paint_and_queue(input fill_cmd_t c, input logic typed,
		input logic [FRAME_W-1:0] typed_frame);
		int               hi;
		int               k;
		logic [COL_W-1:0] colour;
		strip_beat_t      b;
		colour = {c.blue_level[CH_W-1:0], c.red_level[CH_W-1:0], c.green_level[CH_W-1:0]};
		hi = (int'(c.last_index) > NUM_LEDS - 1) ? NUM_LEDS - 1 : int'(c.last_index);
		for (k = int'(c.first_index); k <= hi; k++)
			pixel_colour[k] = colour;
		for (k = 0; k < NUM_LEDS; k++) begin
			b.item_kind    = KIND_FRAME;
			b.frame_word   = typed ? typed_frame : (START_BIT | FRAME_W'(pixel_colour[k]));
			b.latch_clocks = '0;
			b.last_of_run  = 1'b0;
			pending_beats.push_back(b);
		end
		b.item_kind    = KIND_LATCH;
		b.frame_word   = '0;
		b.latch_clocks = CLK_W'(CLKS_PER_LED * NUM_LEDS);
		b.last_of_run  = 1'b1;
		pending_beats.push_back(b);
	endtask

	task automatic offer_cmd(input fill_cmd_t c, input logic typed,
		input logic [FRAME_W-1:0] typed_frame);
		while (tx_idle > 0 && $urandom_range(0, 99) < tx_idle) begin
			fill_bus.valid <= 1'b0;
			@(posedge clk);
		end
		fill_bus.valid       <= 1'b1;
		fill_bus.first_index <= c.first_index;
		fill_bus.last_index  <= c.last_index;
		fill_bus.red_level   <= c.red_level;
		fill_bus.green_level <= c.green_level;
		fill_bus.blue_level  <= c.blue_level;
		do
			@(posedge clk);
		while (!fill_bus.ready);
		paint_and_queue(c, typed, typed_frame);
	endtask

	// receiver, with one long hold-off so the block backs up onto its input
	always @(posedge clk) begin
		if (!arst_n) begin
			strip_bus.ready <= 1'b0;
		end else if (hold_left > 0) begin
			strip_bus.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && beats_seen >= HOLD_AT) begin
			strip_bus.ready <= 1'b0;
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else begin
			strip_bus.ready <= (rx_idle == 0) || ($urandom_range(0, 99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		strip_beat_t want;
		if (arst_n && strip_bus.valid && strip_bus.ready) begin
			beats_seen <= beats_seen + 1;
			if (pending_beats.size() == 0) begin
				$error("unexpected strip beat: kind %0d frame %h", strip_bus.item_kind,
					strip_bus.frame_word);
				failures++;
			end else begin
				want = pending_beats.pop_front();
				if (strip_bus.item_kind !== want.item_kind) begin
					$error("item_kind: expected %0d, got %0d", want.item_kind,
						strip_bus.item_kind);
					failures++;
				end
				if (strip_bus.frame_word !== want.frame_word) begin
					$error("frame_word: expected %h, got %h", want.frame_word,
						strip_bus.frame_word);
					failures++;
				end
				if (strip_bus.latch_clocks !== want.latch_clocks) begin
					$error("latch_clocks: expected %0d, got %0d", want.latch_clocks,
						strip_bus.latch_clocks);
					failures++;
				end
				if (strip_bus.last_of_run !== want.last_of_run) begin
					$error("last_of_run: expected %0d, got %0d", want.last_of_run,
						strip_bus.last_of_run);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_CAP) begin
			$display("** led_strip_fill_and_serialize: FAILED **");
			$finish;
		end
	end

	initial begin
		fill_cmd_t c;
		int        n;
		int        sel;
		fill_bus.valid       <= 1'b0;
		fill_bus.first_index <= '0;
		fill_bus.last_index  <= '0;
		fill_bus.red_level   <= '0;
		fill_bus.green_level <= '0;
		fill_bus.blue_level  <= '0;
		for (n = 0; n < NUM_LEDS; n++)
			pixel_colour[n] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < N_DIRECTED; n++)
			offer_cmd(DIRECTED_ROWS[n].cmd, DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].frame);

		for (n = 0; n < RANDOM_CMDS; n++) begin
			if (n == RANDOM_CMDS / 3) begin
				tx_idle = 70;
				rx_idle = 6;
			end else if (n == 2 * RANDOM_CMDS / 3) begin
				tx_idle = 0;
				rx_idle = 0;
			end
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				c.first_index = IDX_W'($urandom_range(0, NUM_LEDS - 1));
				c.last_index  = IDX_W'($urandom_range(c.first_index, NUM_LEDS - 1));
			end else if (sel < 8) begin
				c.first_index = IDX_W'($urandom_range(0, NUM_LEDS - 1));
				c.last_index  = IDX_W'($urandom_range(NUM_LEDS, 63));
			end else if (sel == 8) begin
				c.first_index = IDX_W'($urandom_range(0, 63));
				c.last_index  = IDX_W'($urandom_range(0, 63));
			end else begin
				c.first_index = IDX_W'($urandom_range(1, 63));
				c.last_index  = IDX_W'($urandom_range(0, c.first_index - 1));
			end
			c.red_level   = LEVEL_W'($urandom_range(0, 255));
			c.green_level = LEVEL_W'($urandom_range(0, 255));
			c.blue_level  = LEVEL_W'($urandom_range(0, 255));
			offer_cmd(c, 1'b0, '0);
		end
		fill_bus.valid <= 1'b0;

		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		if (failures == 0)
			$display("** led_strip_fill_and_serialize: PASSED **");
		else
			$display("** led_strip_fill_and_serialize: FAILED **");
		$finish;
	end

endmodule
